// ===== design/stg_pkg.sv =====
// Shared types, register codes and constants of the sine tremolo gain block.
`default_nettype none

package stg_pkg;

  localparam int WAVE_ENTRIES_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_MS   = 3'd0,
    REG_MOD_DEPTH   = 3'd1,
    REG_START_PHASE = 3'd2,
    REG_SAMPLE_RATE = 3'd3,
    REG_STEREO_MODE = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] PERIOD_RST = 16'd0;
  localparam logic [7:0]  DEPTH_RST  = 8'd0;
  localparam logic [17:0] RATE_RST   = 18'd44100;
  localparam logic        STEREO_RST = 1'b1;

  // Phase step divider: 1000 * 2^32 divided by period_ms * sample_rate.
  localparam int DIVIDEND_W = 42;
  localparam int DEN_W      = 34;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIVIDEND_W-1:0] STEP_DIVIDEND = 42'd1000 << 32;

  // floor(p / 255) for p below 2^24 equals (p * GAIN_RECIP) >> 32 exactly.
  localparam logic [24:0] GAIN_RECIP = 25'd16843010;
  localparam logic [16:0] GAIN_ONE   = 17'h10000;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               block_end_in;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               block_end_out;
  } result_t;

  typedef struct packed {
    logic accept;
    logic den_load;
    logic div_step;
    logic step_load;
    logic gain_mult;
    logic gain_div;
    logic out_load;
  } stg_cmd_t;

  typedef struct packed {
    logic step_dirty;
    logic cfg_write;
    logic div_done;
    logic out_free;
  } stg_status_t;

endpackage

`default_nettype wire

// ===== design/stg_sine_rom.sv =====
// One-period sine table with a registered read port.
`default_nettype none

module stg_sine_rom #(
  parameter int WAVE_ENTRIES = stg_pkg::WAVE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic [$clog2(WAVE_ENTRIES)-1:0]   addr,
  output      logic signed [15:0]                data
);
  import stg_pkg::*;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [WAVE_ENTRIES-1:0][15:0] wave_t;

  // round(32767 * sin(x / N * pi / 2)) by an odd Taylor series in Q30.
  function automatic logic [15:0] quarter_sine(logic [63:0] x);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    a  = (x * HALF_PI_Q30) / WAVE_ENTRIES;
    a2 = (a * a) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic wave_t build_wave();
    wave_t       w;
    logic [63:0] i4;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] n;
    n = 64'(WAVE_ENTRIES);
    for (int i = 0; i < WAVE_ENTRIES; i++) begin
      i4  = 64'(i) * 64'd4;
      q   = i4 / WAVE_ENTRIES;
      rem = i4 - q * n;
      if (q == 64'd0) begin
        w[i] = quarter_sine(rem);
      end else if (q == 64'd1) begin
        w[i] = quarter_sine(n - rem);
      end else if (q == 64'd2) begin
        w[i] = 16'd0 - quarter_sine(rem);
      end else begin
        w[i] = 16'd0 - quarter_sine(n - rem);
      end
    end
    return w;
  endfunction

  localparam wave_t WAVE = build_wave();

  always_ff @(posedge clk) begin
    data <= $signed(WAVE[addr]);
  end

endmodule

`default_nettype wire

// ===== design/stg_dpath.sv =====
// Datapath: configuration registers, phase accumulator, step divider and gain arithmetic.
`default_nettype none

module stg_dpath #(
  parameter int WAVE_ENTRIES = stg_pkg::WAVE_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire stg_pkg::frame_t                  frame,
  input  wire logic                             result_stall,
  output      logic                             result_valid,
  output      stg_pkg::result_t                 result,
  input  wire stg_pkg::stg_cmd_t                cmd,
  output      stg_pkg::stg_status_t             status
);
  import stg_pkg::*;

  localparam int IDX_W      = $clog2(WAVE_ENTRIES);
  localparam int NW         = $clog2(WAVE_ENTRIES + 1);
  localparam int IDX_PROD_W = 32 + NW;

  logic [15:0] period_ms;
  logic [7:0]  mod_depth;
  logic [17:0] sample_rate;
  logic        stereo_mode;

  logic [31:0] phase_accum;
  logic [31:0] phase_step;

  logic [DEN_W-1:0]      den;
  logic [DEN_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DEN_W:0]        rem_shift;
  logic [DEN_W:0]        rem_trial;

  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]      rom_addr;
  logic signed [15:0]    rom_data;
  logic [15:0]           sine_offset;
  logic [23:0]           gprod;
  logic [48:0]           gquot;
  logic [16:0]           gain;
  frame_t                frame_q;
  logic signed [33:0]    left_prod;
  logic signed [33:0]    right_prod;

  stg_sine_rom #(
    .WAVE_ENTRIES(WAVE_ENTRIES)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  // The table index is the top bits of phase times the table length.
  assign idx_prod = IDX_PROD_W'(phase_accum) * IDX_PROD_W'(WAVE_ENTRIES);

  assign rem_shift = {rem, quo[DIVIDEND_W-1]};
  assign rem_trial = rem_shift - {1'b0, den};

  // Sine plus one half scale, as an unsigned value.
  assign sine_offset = {~rom_data[15], rom_data[14:0]};
  assign gquot       = 49'(gprod) * 49'(GAIN_RECIP);

  assign left_prod  = 34'(frame_q.left_in) * 34'($signed({1'b0, gain}));
  assign right_prod = 34'(frame_q.right_in) * 34'($signed({1'b0, gain}));

  assign status.step_dirty = cfg_we && ((cfg_index == REG_PERIOD_MS) ||
                                        (cfg_index == REG_SAMPLE_RATE));
  assign status.cfg_write  = cfg_we;
  assign status.div_done   = (div_cnt == DIV_CNT_W'(DIVIDEND_W - 1));
  assign status.out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms   <= PERIOD_RST;
      mod_depth   <= DEPTH_RST;
      sample_rate <= RATE_RST;
      stereo_mode <= STEREO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_MS:   period_ms   <= cfg_data[15:0];
        REG_MOD_DEPTH:   mod_depth   <= cfg_data[7:0];
        REG_SAMPLE_RATE: sample_rate <= cfg_data[17:0];
        REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
    end else if (cfg_we && (cfg_index == REG_START_PHASE)) begin
      phase_accum <= {4{cfg_data[7:0]}};
    end else if (cmd.accept) begin
      phase_accum <= phase_accum + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cmd.step_load) begin
      if (den == '0) begin
        phase_step <= '0;
      end else if (|quo[DIVIDEND_W-1:32]) begin
        phase_step <= '1;
      end else begin
        phase_step <= quo[31:0];
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den     <= DEN_W'(period_ms) * DEN_W'(sample_rate);
      rem     <= '0;
      quo     <= STEP_DIVIDEND;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!rem_trial[DEN_W]) begin
        rem <= rem_trial[DEN_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      frame_q  <= frame;
      rom_addr <= idx_prod[32 +: IDX_W];
    end
    if (cmd.gain_mult) begin
      gprod <= 24'(sine_offset) * 24'(mod_depth);
    end
    if (cmd.gain_div) begin
      gain <= GAIN_ONE - {1'b0, gquot[47:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // An arithmetic shift by 16 floors the scaled sample.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.left_out      <= left_prod[31:16];
      result.right_out     <= stereo_mode ? right_prod[31:16] : 16'sd0;
      result.block_end_out <= frame_q.block_end_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/stg_ctrl.sv =====
// Controller: sequences the step divider and the per-word gain steps.
`default_nettype none

module stg_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  frame_valid,
  output      logic                  frame_stall,
  input  wire stg_pkg::stg_status_t  status,
  output      stg_pkg::stg_cmd_t     cmd
);
  import stg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN,
    ST_DIV,
    ST_STEP,
    ST_ROM,
    ST_MULT,
    ST_GAIN,
    ST_SCALE
  } state_t;

  state_t state;
  logic   accept;

  // A configuration write blocks the input word in the same cycle.
  assign frame_stall = (state != ST_IDLE) || status.cfg_write;
  assign accept      = (state == ST_IDLE) && frame_valid && !status.cfg_write;

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.den_load  = (state == ST_DEN);
    cmd.div_step  = (state == ST_DIV);
    cmd.step_load = (state == ST_STEP);
    cmd.gain_mult = (state == ST_MULT);
    cmd.gain_div  = (state == ST_GAIN);
    cmd.out_load  = (state == ST_SCALE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      priority if (status.step_dirty) begin
        state <= ST_DEN;
      end else begin
        unique case (state)
          ST_IDLE:  if (accept) state <= ST_ROM;
          ST_DEN:   state <= ST_DIV;
          ST_DIV:   if (status.div_done) state <= ST_STEP;
          ST_STEP:  state <= ST_IDLE;
          ST_ROM:   state <= ST_MULT;
          ST_MULT:  state <= ST_GAIN;
          ST_GAIN:  state <= ST_SCALE;
          ST_SCALE: if (status.out_free) state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sine_tremolo_gain.sv =====
// Top level of the sine tremolo gain block.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   cfg      | cfg_we                     | cfg_index, cfg_data
//   frame    | frame_valid / frame_stall  | frame (left, right, block end)
//   result   | result_valid / result_stall| result (left, right, block end)
//
// The accepting edge registers the table address; these steps then lead to the result
// register: table read, depth multiply, reciprocal divide by 255, sample multiply.
// One word is in flight at a time; a new word is taken after the last leaves the
// final step. Writing period_ms or sample_rate runs the bit-serial step divider,
// which stalls frame input until the step loads; any write blocks input in its cycle.
// Reset returns the controller to idle at once; a stalled result holds the last step.
`default_nettype none

module sine_tremolo_gain #(
  parameter int WAVE_ENTRIES = stg_pkg::WAVE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            frame_valid,
  output      logic                            frame_stall,
  input  wire stg_pkg::frame_t                 frame,
  output      logic                            result_valid,
  input  wire logic                            result_stall,
  output      stg_pkg::result_t                result
);
  import stg_pkg::*;

  stg_cmd_t    cmd;
  stg_status_t status;

  stg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .status     (status),
    .cmd        (cmd)
  );

  stg_dpath #(
    .WAVE_ENTRIES(WAVE_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame       (frame),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== design/stg_check.sv =====
// Port-level checks of the sine tremolo gain block, bound to the top level.
`default_nettype none

module stg_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cfg_we,
  input wire logic              frame_valid,
  input wire logic              frame_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire stg_pkg::result_t  result
);

  // A word waiting in the result register stays there.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result word changed while stalled");

  // Only one word is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !rst && frame_valid && !frame_stall |=> frame_stall)
    else $error("second word accepted while one is in flight");

  // A configuration write never coincides with an accepted word.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> frame_stall)
    else $error("word accepted during a configuration write");

endmodule

bind sine_tremolo_gain stg_check u_check (.*);

`default_nettype wire
